/* hw/rtl/lfpd_pkg.sv */
// Shared types, constants and the microcode program of the line follower steering block.
`default_nettype none

package lfpd_pkg;

    // Field widths of the transfers and the configuration registers.
    localparam int SAMPLE_W = 12;
    localparam int SUM_W    = 14;
    localparam int DRIVE_W  = 10;
    localparam int ERR_W    = 11;
    localparam int LED_W    = 4;
    localparam int TICK_W   = 8;
    localparam int GAIN_W   = 8;
    localparam int SPEED_W  = 10;

    // Defaults of the top level parameters.
    localparam int SAMPLE_BITS_DEF = 12;
    localparam int DRIVE_MAX_DEF   = 950;
    localparam int DRIVE_MIN_DEF   = 50;

    // Steering constants.
    localparam int CENTROID_SCALE = 1000;
    localparam int DIR_THRESHOLD  = 200;
    localparam int TURN_THRESHOLD = 300;
    localparam int RIGHT_GAIN_Q10 = 1178;
    localparam int Q10_SHIFT      = 10;

    localparam logic [LED_W-1:0] LED_OFF    = 4'h0;
    localparam logic [LED_W-1:0] LED_LOST   = 4'hE;
    localparam logic [LED_W-1:0] LED_RIGHT  = 4'h8;
    localparam logic [LED_W-1:0] LED_LEFT   = 4'h2;
    localparam logic [LED_W-1:0] LED_CENTRE = 4'h4;

    // Datapath widths. The centroid numerator |r-l|*1000 stays below 2**22.
    localparam int DIFF_W    = SAMPLE_W + 1;
    localparam int NUM_W     = 22;
    localparam int DIV_STEPS = NUM_W;
    localparam int LOOP_W    = $clog2(DIV_STEPS);
    localparam int DERIV_W   = ERR_W + 1;
    localparam int ACC_W     = 22;
    localparam int PROD_W    = ACC_W + 12;

    // Configuration port.
    localparam int APB_DATA_W = 32;
    localparam int NUM_REGS   = 8;
    localparam int REG_IDX_W  = $clog2(NUM_REGS);
    localparam int APB_ADDR_W = REG_IDX_W + 2;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_LINE_SUM_MIN   = 3'd0,
        REG_WHITE_LIMIT    = 3'd1,
        REG_GAIN_PROP      = 3'd2,
        REG_GAIN_DERIV     = 3'd3,
        REG_SPEED_STRAIGHT = 3'd4,
        REG_SPEED_TURN     = 3'd5,
        REG_SPEED_SEARCH   = 3'd6,
        REG_LOST_DELAY     = 3'd7
    } reg_idx_t;

    localparam logic [SUM_W-1:0]    LINE_SUM_MIN_RST   = 14'd500;
    localparam logic [SAMPLE_W-1:0] WHITE_LIMIT_RST    = 12'd1500;
    localparam logic [GAIN_W-1:0]   GAIN_PROP_RST      = 8'd16;
    localparam logic [GAIN_W-1:0]   GAIN_DERIV_RST     = 8'd30;
    localparam logic [SPEED_W-1:0]  SPEED_STRAIGHT_RST = 10'd650;
    localparam logic [SPEED_W-1:0]  SPEED_TURN_RST     = 10'd300;
    localparam logic [SPEED_W-1:0]  SPEED_SEARCH_RST   = 10'd600;
    localparam logic [TICK_W-1:0]   LOST_DELAY_RST     = 8'd5;

    typedef struct packed {
        logic [SUM_W-1:0]    line_sum_min;
        logic [SAMPLE_W-1:0] white_limit;
        logic [GAIN_W-1:0]   gain_prop;
        logic [GAIN_W-1:0]   gain_deriv;
        logic [SPEED_W-1:0]  speed_straight;
        logic [SPEED_W-1:0]  speed_turn;
        logic [SPEED_W-1:0]  speed_search;
        logic [TICK_W-1:0]   lost_delay;
    } cfg_t;

    typedef enum logic [1:0] {
        SIDE_NONE  = 2'd0,
        SIDE_RIGHT = 2'd1,
        SIDE_LEFT  = 2'd2
    } side_t;

    typedef enum logic {
        SEQ_IDLE,
        SEQ_RUN
    } seq_state_t;

    typedef enum logic [3:0] {
        OP_CHECK,
        OP_PRODUCT,
        OP_DIVSTEP,
        OP_ERR,
        OP_MULP,
        OP_MULD,
        OP_DRIVES,
        OP_LOST,
        OP_SCALE,
        OP_FINISH
    } op_t;

    typedef enum logic [1:0] {
        COND_NONE,
        COND_LOST,
        COND_LOOP,
        COND_ALWAYS
    } cond_t;

    localparam int STEP_W = 4;

    typedef struct packed {
        op_t               op;
        cond_t             cond;
        logic [STEP_W-1:0] target;
        logic              last;
    } ucode_t;

    localparam logic [STEP_W-1:0] ADDR_CHECK   = 4'd0;
    localparam logic [STEP_W-1:0] ADDR_PRODUCT = 4'd1;
    localparam logic [STEP_W-1:0] ADDR_DIV     = 4'd2;
    localparam logic [STEP_W-1:0] ADDR_ERR     = 4'd3;
    localparam logic [STEP_W-1:0] ADDR_MULP    = 4'd4;
    localparam logic [STEP_W-1:0] ADDR_MULD    = 4'd5;
    localparam logic [STEP_W-1:0] ADDR_DRIVES  = 4'd6;
    localparam logic [STEP_W-1:0] ADDR_SCALE   = 4'd7;
    localparam logic [STEP_W-1:0] ADDR_FINISH  = 4'd8;
    localparam logic [STEP_W-1:0] ADDR_LOST    = 4'd9;

    // Microprogram: the line path runs the centroid divide and the PD terms,
    // the lost path sets the search drives and then jumps to the right wheel scaling.
    function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] addr);
        ucode_t uc;
        uc = '{op: OP_FINISH, cond: COND_NONE, target: ADDR_CHECK, last: 1'b1};
        case (addr)
            ADDR_CHECK:   uc = '{OP_CHECK,   COND_LOST,   ADDR_LOST,  1'b0};
            ADDR_PRODUCT: uc = '{OP_PRODUCT, COND_NONE,   ADDR_CHECK, 1'b0};
            ADDR_DIV:     uc = '{OP_DIVSTEP, COND_LOOP,   ADDR_DIV,   1'b0};
            ADDR_ERR:     uc = '{OP_ERR,     COND_NONE,   ADDR_CHECK, 1'b0};
            ADDR_MULP:    uc = '{OP_MULP,    COND_NONE,   ADDR_CHECK, 1'b0};
            ADDR_MULD:    uc = '{OP_MULD,    COND_NONE,   ADDR_CHECK, 1'b0};
            ADDR_DRIVES:  uc = '{OP_DRIVES,  COND_NONE,   ADDR_CHECK, 1'b0};
            ADDR_SCALE:   uc = '{OP_SCALE,   COND_NONE,   ADDR_CHECK, 1'b0};
            ADDR_FINISH:  uc = '{OP_FINISH,  COND_NONE,   ADDR_CHECK, 1'b1};
            ADDR_LOST:    uc = '{OP_LOST,    COND_ALWAYS, ADDR_SCALE, 1'b0};
            default:      uc = '{OP_FINISH,  COND_NONE,   ADDR_CHECK, 1'b1};
        endcase
        return uc;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/lfpd_if.sv */
// Valid/ready channel interfaces for the sensor samples and the steering results.
`default_nettype none

interface lfpd_sensor_if
    import lfpd_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sensor_right;
    logic [SAMPLE_W-1:0] sensor_centre;
    logic [SAMPLE_W-1:0] sensor_left;

    modport source (
        output valid, sensor_right, sensor_centre, sensor_left,
        input  ready
    );
    modport sink (
        input  valid, sensor_right, sensor_centre, sensor_left,
        output ready
    );
endinterface

interface lfpd_drive_if
    import lfpd_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic [DRIVE_W-1:0]      drive_left;
    logic [DRIVE_W-1:0]      drive_right;
    logic                    drive_valid;
    logic [LED_W-1:0]        led_pattern;
    logic                    led_valid;
    logic                    line_lost;
    logic signed [ERR_W-1:0] steer_error;

    modport source (
        output valid, drive_left, drive_right, drive_valid, led_pattern, led_valid,
               line_lost, steer_error,
        input  ready
    );
    modport sink (
        input  valid, drive_left, drive_right, drive_valid, led_pattern, led_valid,
               line_lost, steer_error,
        output ready
    );
endinterface

`default_nettype wire

/* hw/rtl/line_follow_pd_steering.sv */
// A tick that sees the line runs check, product, 22 restoring divide steps, error, two PD
// multiplies, drives, scale and finish; a lost tick runs check, lost, scale and finish. The
// result register drives the output channel; finish waits while a result is unaccepted.
// A new sample is accepted only while the sequencer is idle; the divider gives one bit per step.
// Reset: rst_n clears the sequencer, the error history, the lost counter, the remembered
// side and the output valid, and loads the register defaults.
`default_nettype none

module line_follow_pd_steering
    import lfpd_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int DRIVE_MAX   = DRIVE_MAX_DEF,
    parameter int DRIVE_MIN   = DRIVE_MIN_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    lfpd_sensor_if.sink           sensor,
    lfpd_drive_if.source          drive,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam logic [SAMPLE_W-1:0] SMASK = (SAMPLE_BITS >= SAMPLE_W) ? {SAMPLE_W{1'b1}}
                                          : SAMPLE_W'((1 << SAMPLE_BITS) - 1);
    localparam logic signed [PROD_W-1:0] DMAX     = PROD_W'(DRIVE_MAX);
    localparam logic signed [PROD_W-1:0] DMIN     = PROD_W'(DRIVE_MIN);
    localparam logic signed [ERR_W-1:0]  DIR_HI   = ERR_W'(DIR_THRESHOLD);
    localparam logic signed [ERR_W-1:0]  DIR_LO   = ERR_W'(-DIR_THRESHOLD);
    localparam logic signed [ERR_W-1:0]  TURN_LIM = ERR_W'(TURN_THRESHOLD);
    localparam logic signed [PROD_W-1:0] Q10_BIAS = PROD_W'((1 << Q10_SHIFT) - 1);

    function automatic logic [DRIVE_W-1:0] clamp_drive(input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W-1:0] t;
        t = v;
        if (t > DMAX)
            t = DMAX;
        if (t < DMIN)
            t = DMIN;
        return t[DRIVE_W-1:0];
    endfunction

    cfg_t cfg;

    lfpd_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Sequencer state.
    seq_state_t        state_reg, state_next;
    logic [STEP_W-1:0] pc_reg, pc_next;
    logic [LOOP_W-1:0] cnt_reg, cnt_next;
    ucode_t            uc;
    logic              in_ready;
    logic              step_go;
    logic              jump;
    logic              can_load;
    logic              accept;

    // Datapath state.
    logic [SAMPLE_W-1:0]       sr_reg, sc_reg, sl_reg;
    logic                      lost_reg, lost_next;
    logic                      search_reg, search_next;
    logic                      neg_reg, neg_next;
    logic [TICK_W-1:0]         ticks_reg, ticks_next;
    side_t                     side_reg, side_next;
    logic signed [ERR_W-1:0]   prev_err_reg, prev_err_next;
    logic signed [ERR_W-1:0]   err_reg, err_next;
    logic signed [DERIV_W-1:0] deriv_reg, deriv_next;
    logic [NUM_W-1:0]          div_reg, div_next;
    logic [SUM_W-1:0]          rem_reg, rem_next;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic signed [ACC_W-1:0]   left_reg, left_next;
    logic signed [ACC_W-1:0]   rpre_reg, rpre_next;
    logic signed [PROD_W-1:0]  prod_reg, prod_next;

    // Result register.
    logic                    out_valid_reg, out_valid_next;
    logic [DRIVE_W-1:0]      out_left_reg, out_left_next;
    logic [DRIVE_W-1:0]      out_right_reg, out_right_next;
    logic                    out_dvalid_reg, out_dvalid_next;
    logic [LED_W-1:0]        out_led_reg, out_led_next;
    logic                    out_lvalid_reg, out_lvalid_next;
    logic                    out_lost_reg, out_lost_next;
    logic signed [ERR_W-1:0] out_err_reg, out_err_next;

    // Combinational datapath terms.
    logic [SUM_W-1:0]          sum;
    logic                      lost_now;
    logic signed [DIFF_W-1:0]  diff;
    logic [SAMPLE_W-1:0]       mag;
    logic [SUM_W:0]            trial;
    logic                      trial_ge;
    logic signed [ERR_W-1:0]   err_calc;
    logic signed [ERR_W-1:0]   abs_err;
    logic [SPEED_W-1:0]        base;
    logic signed [ACC_W-1:0]   base_s;
    logic signed [ACC_W-1:0]   search_s;
    logic signed [PROD_W-1:0]  rbias;
    logic signed [PROD_W-1:0]  rscaled;
    logic [LED_W-1:0]          led_dir;

    assign uc       = ucode_rom(pc_reg);
    assign can_load = !out_valid_reg || drive.ready;
    assign accept   = sensor.valid && in_ready;
    assign sensor.ready = in_ready;

    assign sum = SUM_W'(sr_reg) + SUM_W'(sc_reg) + SUM_W'(sl_reg);
    assign lost_now = (sum == '0) || (sum < cfg.line_sum_min) ||
                      ((sr_reg < cfg.white_limit) && (sc_reg < cfg.white_limit) &&
                       (sl_reg < cfg.white_limit));

    assign diff     = $signed({1'b0, sr_reg}) - $signed({1'b0, sl_reg});
    assign mag      = diff[DIFF_W-1] ? SAMPLE_W'(-diff) : diff[SAMPLE_W-1:0];
    assign trial    = {rem_reg, div_reg[NUM_W-1]};
    assign trial_ge = trial >= {1'b0, sum};
    assign err_calc = neg_reg ? -$signed({1'b0, div_reg[ERR_W-2:0]})
                              :  $signed({1'b0, div_reg[ERR_W-2:0]});
    assign abs_err  = err_reg[ERR_W-1] ? -err_reg : err_reg;
    assign base     = (abs_err > TURN_LIM) ? cfg.speed_turn : cfg.speed_straight;
    assign base_s   = ACC_W'($signed({1'b0, base}));
    assign search_s = ACC_W'($signed({1'b0, cfg.speed_search}));

    // Q10 scaling truncates toward zero: negative products get a bias before the arithmetic shift.
    assign rbias    = prod_reg + (prod_reg[PROD_W-1] ? Q10_BIAS : '0);
    assign rscaled  = rbias >>> Q10_SHIFT;
    assign led_dir  = (err_reg > DIR_HI) ? LED_RIGHT :
                      (err_reg < DIR_LO) ? LED_LEFT : LED_CENTRE;

    // Sequencer: next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            SEQ_IDLE:
                if (sensor.valid)
                    state_next = SEQ_RUN;
            SEQ_RUN:
                if (uc.last && can_load)
                    state_next = SEQ_IDLE;
            default:
                state_next = SEQ_IDLE;
        endcase
    end

    // Sequencer: outputs.
    always_comb
    begin
        in_ready = 1'b0;
        step_go  = 1'b0;
        unique case (state_reg)
            SEQ_IDLE:
                in_ready = 1'b1;
            SEQ_RUN:
                step_go = !uc.last || can_load;
            default:
                in_ready = 1'b0;
        endcase
    end

    always_comb
    begin
        unique case (uc.cond)
            COND_NONE:   jump = 1'b0;
            COND_LOST:   jump = lost_now;
            COND_LOOP:   jump = cnt_reg != '0;
            COND_ALWAYS: jump = 1'b1;
            default:     jump = 1'b0;
        endcase
    end

    always_comb
    begin
        pc_next = pc_reg;
        if (accept)
            pc_next = ADDR_CHECK;
        else if (step_go)
        begin
            if (uc.last)
                pc_next = ADDR_CHECK;
            else if (jump)
                pc_next = uc.target;
            else
                pc_next = pc_reg + STEP_W'(1);
        end
    end

    // Datapath: one operation per control word.
    always_comb
    begin
        cnt_next        = cnt_reg;
        lost_next       = lost_reg;
        search_next     = search_reg;
        neg_next        = neg_reg;
        ticks_next      = ticks_reg;
        side_next       = side_reg;
        prev_err_next   = prev_err_reg;
        err_next        = err_reg;
        deriv_next      = deriv_reg;
        div_next        = div_reg;
        rem_next        = rem_reg;
        acc_next        = acc_reg;
        left_next       = left_reg;
        rpre_next       = rpre_reg;
        prod_next       = prod_reg;
        out_valid_next  = out_valid_reg && !drive.ready;
        out_left_next   = out_left_reg;
        out_right_next  = out_right_reg;
        out_dvalid_next = out_dvalid_reg;
        out_led_next    = out_led_reg;
        out_lvalid_next = out_lvalid_reg;
        out_lost_next   = out_lost_reg;
        out_err_next    = out_err_reg;

        if (step_go)
        begin
            unique case (uc.op)
                OP_CHECK:
                begin
                    lost_next   = lost_now;
                    search_next = 1'b0;
                    if (!lost_now)
                        ticks_next = '0;
                    else if (ticks_reg != {TICK_W{1'b1}})
                        ticks_next = ticks_reg + TICK_W'(1);
                end
                OP_PRODUCT:
                begin
                    div_next = NUM_W'(mag) * NUM_W'(CENTROID_SCALE);
                    rem_next = '0;
                    neg_next = diff[DIFF_W-1];
                    cnt_next = LOOP_W'(DIV_STEPS - 1);
                end
                OP_DIVSTEP:
                begin
                    rem_next = trial_ge ? SUM_W'(trial - {1'b0, sum}) : SUM_W'(trial);
                    div_next = {div_reg[NUM_W-2:0], trial_ge};
                    if (cnt_reg != '0)
                        cnt_next = cnt_reg - LOOP_W'(1);
                end
                OP_ERR:
                begin
                    err_next      = err_calc;
                    deriv_next    = DERIV_W'(err_calc) - DERIV_W'(prev_err_reg);
                    prev_err_next = err_calc;
                    if (err_calc > DIR_HI)
                        side_next = SIDE_RIGHT;
                    else if (err_calc < DIR_LO)
                        side_next = SIDE_LEFT;
                end
                OP_MULP:
                    acc_next = ACC_W'(err_reg) * ACC_W'($signed({1'b0, cfg.gain_prop}));
                OP_MULD:
                    acc_next = acc_reg +
                               ACC_W'(deriv_reg) * ACC_W'($signed({1'b0, cfg.gain_deriv}));
                OP_DRIVES:
                begin
                    left_next = base_s + acc_reg;
                    rpre_next = base_s - acc_reg;
                end
                OP_LOST:
                begin
                    search_next = ticks_reg > cfg.lost_delay;
                    if (side_reg == SIDE_RIGHT)
                    begin
                        left_next = search_s;
                        rpre_next = '0;
                    end
                    else
                    begin
                        left_next = '0;
                        rpre_next = search_s;
                    end
                end
                OP_SCALE:
                    prod_next = PROD_W'(rpre_reg) * PROD_W'(RIGHT_GAIN_Q10);
                OP_FINISH:
                begin
                    out_valid_next = 1'b1;
                    out_lost_next  = lost_reg;
                    if (!lost_reg || search_reg)
                    begin
                        out_left_next   = clamp_drive(PROD_W'(left_reg));
                        out_right_next  = clamp_drive(rscaled);
                        out_dvalid_next = 1'b1;
                        out_lvalid_next = 1'b1;
                        out_led_next    = lost_reg ? LED_LOST : led_dir;
                    end
                    else
                    begin
                        out_left_next   = '0;
                        out_right_next  = '0;
                        out_dvalid_next = 1'b0;
                        out_lvalid_next = 1'b0;
                        out_led_next    = LED_OFF;
                    end
                    out_err_next = lost_reg ? '0 : err_reg;
                end
                default:
                    out_valid_next = out_valid_reg && !drive.ready;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= SEQ_IDLE;
            pc_reg        <= ADDR_CHECK;
            cnt_reg       <= '0;
            lost_reg      <= 1'b0;
            search_reg    <= 1'b0;
            neg_reg       <= 1'b0;
            ticks_reg     <= '0;
            side_reg      <= SIDE_NONE;
            prev_err_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            cnt_reg       <= cnt_next;
            lost_reg      <= lost_next;
            search_reg    <= search_next;
            neg_reg       <= neg_next;
            ticks_reg     <= ticks_next;
            side_reg      <= side_next;
            prev_err_reg  <= prev_err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sr_reg <= sensor.sensor_right & SMASK;
            sc_reg <= sensor.sensor_centre & SMASK;
            sl_reg <= sensor.sensor_left & SMASK;
        end
        err_reg        <= err_next;
        deriv_reg      <= deriv_next;
        div_reg        <= div_next;
        rem_reg        <= rem_next;
        acc_reg        <= acc_next;
        left_reg       <= left_next;
        rpre_reg       <= rpre_next;
        prod_reg       <= prod_next;
        out_left_reg   <= out_left_next;
        out_right_reg  <= out_right_next;
        out_dvalid_reg <= out_dvalid_next;
        out_led_reg    <= out_led_next;
        out_lvalid_reg <= out_lvalid_next;
        out_lost_reg   <= out_lost_next;
        out_err_reg    <= out_err_next;
    end

    assign drive.valid       = out_valid_reg;
    assign drive.drive_left  = out_left_reg;
    assign drive.drive_right = out_right_reg;
    assign drive.drive_valid = out_dvalid_reg;
    assign drive.led_pattern = out_led_reg;
    assign drive.led_valid   = out_lvalid_reg;
    assign drive.line_lost   = out_lost_reg;
    assign drive.steer_error = out_err_reg;

endmodule

`default_nettype wire

/* hw/rtl/lfpd_cfg.sv */
// APB configuration register file of the line follower steering block.
`default_nettype none

module lfpd_cfg
    import lfpd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_LINE_SUM_MIN:   cfg_next.line_sum_min   = pwdata[SUM_W-1:0];
                REG_WHITE_LIMIT:    cfg_next.white_limit    = pwdata[SAMPLE_W-1:0];
                REG_GAIN_PROP:      cfg_next.gain_prop      = pwdata[GAIN_W-1:0];
                REG_GAIN_DERIV:     cfg_next.gain_deriv     = pwdata[GAIN_W-1:0];
                REG_SPEED_STRAIGHT: cfg_next.speed_straight = pwdata[SPEED_W-1:0];
                REG_SPEED_TURN:     cfg_next.speed_turn     = pwdata[SPEED_W-1:0];
                REG_SPEED_SEARCH:   cfg_next.speed_search   = pwdata[SPEED_W-1:0];
                REG_LOST_DELAY:     cfg_next.lost_delay     = pwdata[TICK_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_LINE_SUM_MIN:   prdata = APB_DATA_W'(cfg_reg.line_sum_min);
            REG_WHITE_LIMIT:    prdata = APB_DATA_W'(cfg_reg.white_limit);
            REG_GAIN_PROP:      prdata = APB_DATA_W'(cfg_reg.gain_prop);
            REG_GAIN_DERIV:     prdata = APB_DATA_W'(cfg_reg.gain_deriv);
            REG_SPEED_STRAIGHT: prdata = APB_DATA_W'(cfg_reg.speed_straight);
            REG_SPEED_TURN:     prdata = APB_DATA_W'(cfg_reg.speed_turn);
            REG_SPEED_SEARCH:   prdata = APB_DATA_W'(cfg_reg.speed_search);
            REG_LOST_DELAY:     prdata = APB_DATA_W'(cfg_reg.lost_delay);
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.line_sum_min   <= LINE_SUM_MIN_RST;
            cfg_reg.white_limit    <= WHITE_LIMIT_RST;
            cfg_reg.gain_prop      <= GAIN_PROP_RST;
            cfg_reg.gain_deriv     <= GAIN_DERIV_RST;
            cfg_reg.speed_straight <= SPEED_STRAIGHT_RST;
            cfg_reg.speed_turn     <= SPEED_TURN_RST;
            cfg_reg.speed_search   <= SPEED_SEARCH_RST;
            cfg_reg.lost_delay     <= LOST_DELAY_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/lfpd_checker.sv */
// Port-level assertions of the line follower steering block and their bind.
`default_nettype none

module lfpd_checker
    import lfpd_pkg::*;
(
    input wire logic                    clk,
    input wire logic                    rst_n,
    input wire logic                    in_valid,
    input wire logic                    in_ready,
    input wire logic                    out_valid,
    input wire logic                    out_ready,
    input wire logic [DRIVE_W-1:0]      drive_left,
    input wire logic [DRIVE_W-1:0]      drive_right,
    input wire logic                    drive_valid,
    input wire logic [LED_W-1:0]        led_pattern,
    input wire logic                    led_valid,
    input wire logic                    line_lost,
    input wire logic signed [ERR_W-1:0] steer_error
);

    // A result that waits for the sink keeps its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(drive_left) &&
        $stable(drive_right) && $stable(led_pattern) && $stable(steer_error))
    else $error("result changed while stalled");

    // The block works on one tick at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
    else $error("second sample transfer while busy");

    // A tick without drive update is a lost tick inside the delay and shows nothing.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !drive_valid |-> line_lost && !led_valid &&
        drive_left == '0 && drive_right == '0 && led_pattern == LED_OFF)
    else $error("idle result carries values");

    // A lost tick reports no error.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && line_lost |-> steer_error == '0)
    else $error("error reported on a lost tick");

    // A tick that sees the line updates drives and shows a direction LED.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !line_lost |-> drive_valid && led_valid &&
        (led_pattern == LED_RIGHT || led_pattern == LED_LEFT || led_pattern == LED_CENTRE))
    else $error("line tick without drive or direction");

endmodule

bind line_follow_pd_steering lfpd_checker u_lfpd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (sensor.valid),
    .in_ready    (sensor.ready),
    .out_valid   (drive.valid),
    .out_ready   (drive.ready),
    .drive_left  (drive.drive_left),
    .drive_right (drive.drive_right),
    .drive_valid (drive.drive_valid),
    .led_pattern (drive.led_pattern),
    .led_valid   (drive.led_valid),
    .line_lost   (drive.line_lost),
    .steer_error (drive.steer_error)
);

`default_nettype wire
